[rtl/core/ckte_pkg.sv]
// Shared types, key positions, codes and character tables of the chord keypad encoder.
package ckte_pkg;

  localparam int NumKeys = 10;
  localparam int CodeW   = 8;

  // Key positions in the sample word
  localparam int KeyA     = 0;
  localparam int KeyB     = 1;
  localparam int KeySel   = 2;
  localparam int KeyStart = 3;
  localparam int KeyRight = 4;
  localparam int KeyLeft  = 5;
  localparam int KeyUp    = 6;
  localparam int KeyDown  = 7;
  localparam int KeyR     = 8;
  localparam int KeyL     = 9;

  // Direction, A and B keys taken into a chord
  localparam logic [7:0] ChordKeys = 8'hF3;

  // Emitted control codes
  localparam logic [CodeW-1:0] CodeTab   = 8'd9;
  localparam logic [CodeW-1:0] CodeEsc   = 8'd27;
  localparam logic [CodeW-1:0] CodeBs    = 8'd8;
  localparam logic [CodeW-1:0] CodeSpace = 8'd32;
  localparam logic [CodeW-1:0] CodeNl    = 8'd10;

  // Group codes
  localparam logic [2:0] GrpNone = 3'd0;
  localparam logic [2:0] GrpR    = 3'd1;
  localparam logic [2:0] GrpL    = 3'd2;
  localparam logic [2:0] GrpBoth = 3'd3;
  localparam logic [2:0] GrpAlt  = 3'd4;

  // Raw event report order: L, R, Select, Start, Up, Down, Right, Left, A, B
  localparam logic [3:0] RawOrder [NumKeys] = '{
    4'd9, 4'd8, 4'd2, 4'd3, 4'd6, 4'd7, 4'd4, 4'd5, 4'd0, 4'd1
  };

  // Character rows; the special entries are already mapped (newline, backspace)
  localparam logic [7:0] Row0 [NumKeys] = '{
    "r", "t", "y", "f", "h", "v", "b", "n", "g", " "
  };
  localparam logic [7:0] Row1 [NumKeys] = '{
    "u", "i", "o", "j", "l", "m", ",", ".", "k", "p"
  };
  localparam logic [7:0] Row2 [NumKeys] = '{
    "q", "w", "e", "a", "d", "z", "x", "c", "s", 8'h5C
  };
  localparam logic [7:0] Row3 [NumKeys] = '{
    "p", 8'd8, 8'd8, ";", "#", ",", ".", " ", 8'h27, 8'd10
  };
  localparam logic [7:0] Row4 [NumKeys] = '{
    "7", "8", "9", "4", "6", "1", "2", "3", "5", "0"
  };

  // One frame's worth of results: a slot per possible code plus status
  typedef struct packed {
    logic [NumKeys-1:0]            pending;
    logic [NumKeys-1:0][CodeW-1:0] codes;
    logic [2:0]                    group;
    logic                          show;
    logic                          rst_req;
  } frame_t;

  // Chord to table position; bit 4 marks a recognized chord
  function automatic logic [4:0] chord_pos(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    unique case (c)
      8'h60:   r = {1'b1, 4'd0};
      8'h40:   r = {1'b1, 4'd1};
      8'h50:   r = {1'b1, 4'd2};
      8'h20:   r = {1'b1, 4'd3};
      8'h10:   r = {1'b1, 4'd4};
      8'hA0:   r = {1'b1, 4'd5};
      8'h80:   r = {1'b1, 4'd6};
      8'h90:   r = {1'b1, 4'd7};
      8'h01:   r = {1'b1, 4'd8};
      8'h02:   r = {1'b1, 4'd9};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Character of a group at a chord position
  function automatic logic [7:0] group_char(input logic [2:0] g, input logic [3:0] p);
    logic [7:0] c;
    c = 8'd0;
    if (p < 4'(NumKeys)) begin
      unique case (g)
        3'd0:    c = Row0[p];
        3'd1:    c = Row1[p];
        3'd2:    c = Row2[p];
        3'd3:    c = Row3[p];
        3'd4:    c = Row4[p];
        default: c = 8'd0;
      endcase
    end
    return c;
  endfunction

endpackage

[rtl/core/ckte_frame.sv]
// Per-frame decode: key edges, group choice, chord tracking and the frame's code slots.
module ckte_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  raw_mode,
  input  logic [9:0]            key_lines,
  output ckte_pkg::frame_t      rec
);

  logic [9:0] previous_keys;
  logic [2:0] group_sel;
  logic [7:0] chord_mask;
  logic       show_on;

  logic [9:0] keys;
  logic [9:0] rise;
  logic [9:0] chg;
  logic [2:0] group_next;
  logic       show_next;
  logic [7:0] chord_next;
  logic [7:0] ck;
  logic [4:0] cpos;
  logic       hold_r;
  logic       hold_l;

  assign keys   = ~key_lines;
  assign rise   = keys & ~previous_keys;
  assign chg    = keys ^ previous_keys;
  assign hold_r = keys[ckte_pkg::KeyR];
  assign hold_l = keys[ckte_pkg::KeyL];
  assign ck     = keys[7:0] & ckte_pkg::ChordKeys;
  assign cpos   = ckte_pkg::chord_pos(chord_mask);

  // Shoulder group; both shoulders flip to the alternate group from L or alternate
  always_comb begin
    group_next = {1'b0, hold_l, hold_r};
    if (group_next == ckte_pkg::GrpBoth &&
        (group_sel == ckte_pkg::GrpL || group_sel == ckte_pkg::GrpAlt)) begin
      group_next = ckte_pkg::GrpAlt;
    end
  end

  // Select toggles the overlay when no shoulder is held
  assign show_next = show_on ^ (rise[ckte_pkg::KeySel] & ~hold_r & ~hold_l);

  // Chord grows while any chord key is held, clears on full release
  assign chord_next = (ck != 8'd0) ? (chord_mask | ck) : 8'd0;

  // Code slots for this frame
  always_comb begin
    rec.pending = '0;
    rec.codes   = '0;
    rec.rst_req = keys[ckte_pkg::KeySel] & keys[ckte_pkg::KeyStart];
    if (raw_mode) begin
      rec.group = group_sel;
      rec.show  = show_on;
      for (int k = 0; k < ckte_pkg::NumKeys; k++) begin
        rec.pending[k] = chg[ckte_pkg::RawOrder[k]];
        rec.codes[k]   = {~keys[ckte_pkg::RawOrder[k]], 3'b000, ckte_pkg::RawOrder[k]};
      end
    end else begin
      rec.group = group_next;
      rec.show  = show_next;
      // Select: Tab or Esc
      rec.pending[0] = rise[ckte_pkg::KeySel] & (hold_r | hold_l);
      rec.codes[0]   = hold_r ? ckte_pkg::CodeTab : ckte_pkg::CodeEsc;
      // Start: backspace, space or newline
      rec.pending[1] = rise[ckte_pkg::KeyStart];
      rec.codes[1]   = hold_r ? ckte_pkg::CodeBs :
                       hold_l ? ckte_pkg::CodeSpace : ckte_pkg::CodeNl;
      // Chord character on release
      rec.pending[2] = (ck == 8'd0) & cpos[4];
      rec.codes[2]   = ckte_pkg::group_char(group_next, cpos[3:0]);
    end
  end

  // Key history and chord state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
      group_sel     <= '0;
      chord_mask    <= '0;
      show_on       <= 1'b0;
    end else if (load) begin
      previous_keys <= keys;
      if (!raw_mode) begin
        group_sel  <= group_next;
        chord_mask <= chord_next;
        show_on    <= show_next;
      end
    end
  end

endmodule

[rtl/core/ckte_drain.sv]
// Result register: holds one frame's code slots; one beat per cycle unless stalled.
module ckte_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ckte_pkg::frame_t rec_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             has_char,
  output logic [7:0]       char_code,
  output logic             last_of_frame,
  output logic [2:0]       group_now,
  output logic             show_flag,
  output logic             reset_request
);

  logic             full;
  ckte_pkg::frame_t rec;

  logic [ckte_pkg::NumKeys-1:0] pick;
  logic [ckte_pkg::NumKeys-1:0] rest;
  logic [7:0]                   code_sel;
  logic                         fire;

  // Lowest pending slot goes out first
  assign pick = rec.pending & (~rec.pending + 10'd1);
  assign rest = rec.pending & ~pick;

  always_comb begin
    code_sel = 8'd0;
    for (int k = 0; k < ckte_pkg::NumKeys; k++) begin
      code_sel = code_sel | (rec.codes[k] & {8{pick[k]}});
    end
  end

  assign out_valid     = full;
  assign has_char      = (rec.pending != '0);
  assign char_code     = code_sel;
  assign last_of_frame = (rest == '0);
  assign group_now     = rec.group;
  assign show_flag     = rec.show;
  assign reset_request = rec.rst_req;

  assign fire     = full & ~out_stall;
  assign can_load = ~full | (fire & last_of_frame);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (fire && last_of_frame) begin
      full <= 1'b0;
    end
  end

  // Frame record; a delivered slot is retired
  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end else if (fire) begin
      rec.pending <= rest;
    end
  end

endmodule

[rtl/core/chord_keypad_text_encoder_core.sv]
// Top level of the chord keypad text encoder: config register, frame decode and result drain.
// One key sample beat is taken per frame and decoded in the same cycle into a result
// register holding every code the frame produces. Results then leave one beat per
// cycle while out_stall is low: a frame with n codes (up to three in chord mode, up to ten
// in raw mode) yields n beats, and a frame with no code yields one status-only beat with
// has_char low. A new sample is taken in the cycle the last beat of the previous frame is
// taken, as the single result register and its one-code-per-beat output allow no overlap.
// last_of_frame marks the final beat of each frame.
module chord_keypad_text_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] key_lines,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       has_char,
  output logic [7:0] char_code,
  output logic       last_of_frame,
  output logic [2:0] group_now,
  output logic       show_flag,
  output logic       reset_request
);

  logic             raw_mode;
  logic             can_load;
  logic             load;
  ckte_pkg::frame_t rec;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      raw_mode <= cfg_wr_data;
    end
  end

  assign in_stall = ~can_load;
  assign load     = in_valid & can_load;

  ckte_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .raw_mode  (raw_mode),
    .key_lines (key_lines),
    .rec       (rec)
  );

  ckte_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .rec_in        (rec),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .has_char      (has_char),
    .char_code     (char_code),
    .last_of_frame (last_of_frame),
    .group_now     (group_now),
    .show_flag     (show_flag),
    .reset_request (reset_request)
  );

`ifndef SYNTHESIS
  // An accepted sample always has a result beat waiting next cycle
  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted sample left no result");

  // Only the final beat of a frame may be status-only
  a_inner_beats_carry_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_frame) |-> has_char)
    else $error("non-final beat without a code");

  // Input is held back only while a result is pending
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // Group stays within its five codes
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (group_now <= ckte_pkg::GrpAlt))
    else $error("group out of range");
`endif

endmodule
